// File: sv/poe_pkg.sv
// poe_pkg: types, codes and command/status structs of the pool allocator
// no dependencies; used by the request and response interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none
package poe_pkg;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_REAP  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DUMMY    = 2'd1;
   localparam logic [1:0] ST_INACTIVE = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now;
      logic [23:0] duration;
      logic [8:0]  slot;
   } poe_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [8:0] result_slot;
      logic       evicted;
      logic [8:0] evicted_slot;
      logic [9:0] active_count;
   } poe_rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_RD_OLDEST,
      DP_RD_REQ,
      DP_RD_HEAD,
      DP_WALK,
      DP_REL_A,
      DP_REL_B,
      DP_POP_A,
      DP_POP_B,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] status;
   } poe_cmd_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       head_nil;
      logic       oldest_nil;
      logic       cur_nil;
      logic       cur_active;
      logic       expired;
      logic       rsp_free;
   } poe_stat_type;

endpackage
`default_nettype wire

// File: sv/poe_if.sv
// poe_if: valid/ready channel interfaces for request, response and csr write
// depends on poe_pkg
`timescale 1ns / 1ps
`default_nettype none
interface poe_req_if import poe_pkg::*; ();
   logic        valid;
   logic        ready;
   poe_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface poe_rsp_if import poe_pkg::*; ();
   logic        valid;
   logic        ready;
   poe_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface poe_csr_if ();
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/poe_datapath.sv
// poe_datapath: link memories, list pointers, walk register and response register
// depends on poe_pkg; driven by poe_ctrl commands
`timescale 1ns / 1ps
`default_nettype none
module poe_datapath import poe_pkg::*; #(
   parameter int POOL_ENTRIES = 512
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire poe_req_type  req_data,
   input  wire poe_cmd_type  cmd,
   output poe_stat_type      stat,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output poe_rsp_type       rsp_data
);
   localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

   logic [LW-1:0] next_mem [POOL_ENTRIES];
   logic [LW-1:0] prev_mem [POOL_ENTRIES];
   logic [31:0]   end_mem  [POOL_ENTRIES];
   logic          act_mem  [POOL_ENTRIES];

   logic [LW-1:0] next_q, prev_q;
   logic [31:0]   end_q;
   logic          act_q;

   logic [LW-1:0] free_head_ff, free_head_in, newest_ff, newest_in, oldest_ff, oldest_in;
   logic [LW-1:0] count_ff, count_in, fill_ff, fill_in, cur_ff, cur_in;
   logic [1:0]    op_ff;
   logic [31:0]   now_ff;
   logic [23:0]   dur_ff;
   logic [8:0]    slot_ff;
   logic          slot_ok_ff;
   logic [8:0]    rslot_ff, rslot_in, evslot_ff, evslot_in;
   logic          ev_ff, ev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   poe_rsp_type   rsp_ff, rsp_in;

   logic          rd_en;
   logic [LW-1:0] rd_addr;
   logic          nx_we, pv_we, en_we, ac_we, ac_wd;
   logic [LW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, en_wa, ac_wa;
   logic [32:0]   sum;
   logic [31:0]   end_sat;
   logic [LW-1:0] pop_next;

   assign sum      = {1'b0, now_ff} + 33'(dur_ff);
   assign end_sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign pop_next = (cur_ff >= fill_ff) ? cur_ff + LW'(1) : next_q;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_ff;
      case (cmd.op)
         DP_RD_OLDEST: begin rd_en = 1'b1; rd_addr = oldest_ff; end
         DP_RD_REQ:    begin rd_en = 1'b1; rd_addr = LW'(slot_ff); end
         DP_RD_HEAD:   begin rd_en = 1'b1; rd_addr = free_head_ff; end
         DP_WALK:      begin rd_en = 1'b1; rd_addr = prev_q; end
         default:      ;
      endcase
   end

   always_comb begin
      nx_we = 1'b0; nx_wa = cur_ff; nx_wd = free_head_ff;
      pv_we = 1'b0; pv_wa = cur_ff; pv_wd = NIL;
      en_we = 1'b0; en_wa = cur_ff;
      ac_we = 1'b0; ac_wa = cur_ff; ac_wd = 1'b0;
      free_head_in = free_head_ff;
      newest_in    = newest_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      cur_in       = rd_en ? rd_addr : cur_ff;
      rslot_in     = rslot_ff;
      ev_in        = ev_ff;
      evslot_in    = evslot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (cmd.op)
         DP_LOAD: begin
            rslot_in  = (req_data.operation == OP_FREE) ? req_data.slot : 9'd0;
            ev_in     = 1'b0;
            evslot_in = 9'd0;
         end
         DP_REL_A: begin
            if (prev_q != NIL) begin
               nx_we = 1'b1; nx_wa = prev_q; nx_wd = next_q;
            end else begin
               newest_in = next_q;
            end
            if (next_q != NIL) begin
               pv_we = 1'b1; pv_wa = next_q; pv_wd = prev_q;
            end else begin
               oldest_in = prev_q;
            end
            ac_we = 1'b1; ac_wd = 1'b0;
            if (count_ff != '0) count_in = count_ff - LW'(1);
         end
         DP_REL_B: begin
            nx_we = 1'b1; nx_wd = free_head_ff;
            free_head_in = cur_ff;
            if (op_ff == OP_ALLOC) begin
               ev_in = 1'b1; evslot_in = 9'(cur_ff);
            end else begin
               rslot_in = 9'(cur_ff);
            end
         end
         DP_POP_A: begin
            free_head_in = pop_next;
            if (cur_ff == fill_ff) fill_in = fill_ff + LW'(1);
            nx_we = 1'b1; nx_wd = newest_ff;
            pv_we = 1'b1; pv_wd = NIL;
            en_we = 1'b1;
            ac_we = 1'b1; ac_wd = 1'b1;
         end
         DP_POP_B: begin
            if (newest_ff != NIL) begin
               pv_we = 1'b1; pv_wa = newest_ff; pv_wd = cur_ff;
            end else begin
               oldest_in = cur_ff;
            end
            newest_in = cur_ff;
            count_in  = count_ff + LW'(1);
            rslot_in  = 9'(cur_ff);
         end
         DP_FINISH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = cmd.status;
            rsp_in.result_slot  = rslot_ff;
            rsp_in.evicted      = ev_ff;
            rsp_in.evicted_slot = evslot_ff;
            rsp_in.active_count = 10'(count_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         next_q <= next_mem[rd_addr[IW-1:0]];
         prev_q <= prev_mem[rd_addr[IW-1:0]];
         end_q  <= end_mem[rd_addr[IW-1:0]];
         act_q  <= act_mem[rd_addr[IW-1:0]];
      end
      if (nx_we) next_mem[nx_wa[IW-1:0]] <= nx_wd;
      if (pv_we) prev_mem[pv_wa[IW-1:0]] <= pv_wd;
      if (en_we) end_mem[en_wa[IW-1:0]] <= end_sat;
      if (ac_we) act_mem[ac_wa[IW-1:0]] <= ac_wd;
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      rslot_ff  <= rslot_in;
      ev_ff     <= ev_in;
      evslot_ff <= evslot_in;
      rsp_ff    <= rsp_in;
      if (cmd.op == DP_LOAD) begin
         op_ff      <= req_data.operation;
         now_ff     <= req_data.now;
         dur_ff     <= req_data.duration;
         slot_ff    <= req_data.slot;
         slot_ok_ff <= 32'(req_data.slot) < 32'(POOL_ENTRIES);
      end
      if (reset) begin
         free_head_ff <= '0;
         newest_ff    <= NIL;
         oldest_ff    <= NIL;
         count_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.operation  = op_ff;
   assign stat.head_nil   = free_head_ff == NIL;
   assign stat.oldest_nil = oldest_ff == NIL;
   assign stat.cur_nil    = cur_ff == NIL;
   assign stat.cur_active = slot_ok_ff && (cur_ff < fill_ff) && act_q;
   assign stat.expired    = now_ff >= end_q;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL && fill_ff <= NIL) else $error("count or fill out of range");
   a_ends_agree: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff == NIL) == (newest_ff == NIL)) else $error("list ends disagree");
   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (oldest_ff == NIL)) else $error("count disagrees with list");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_FINISH |-> !rsp_valid_ff || rsp_ready) else $error("response overrun");
`endif
endmodule
`default_nettype wire

// File: sv/poe_ctrl.sv
// poe_ctrl: sequencer for alloc, free and reap, plus the suppress register
// depends on poe_pkg and poe_if; drives poe_datapath commands
`timescale 1ns / 1ps
`default_nettype none
module poe_ctrl import poe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   poe_csr_if.sink      csr_bus,
   input  wire poe_stat_type stat,
   output poe_cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_HEAD_RD, S_POP_A, S_POP_B,
      S_FREE_CHK, S_REL_A, S_REL_B, S_WALK, S_DONE
   } state_type;

   state_type  state_ff;
   logic       suppress_ff;
   logic [1:0] status_ff;

   assign req_ready     = state_ff == S_IDLE;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cmd.op     = DP_NOP;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) cmd.op = DP_LOAD;
         S_DISPATCH: begin
            case (stat.operation)
               OP_ALLOC: if (!suppress_ff) begin
                  if (stat.head_nil && !stat.oldest_nil) cmd.op = DP_RD_OLDEST;
                  else if (!stat.head_nil) cmd.op = DP_RD_HEAD;
               end
               OP_FREE: cmd.op = DP_RD_REQ;
               OP_REAP: cmd.op = DP_RD_OLDEST;
               default: ;
            endcase
         end
         S_HEAD_RD:  cmd.op = DP_RD_HEAD;
         S_POP_A:    cmd.op = DP_POP_A;
         S_POP_B:    cmd.op = DP_POP_B;
         S_FREE_CHK: ;
         S_REL_A:    cmd.op = DP_REL_A;
         S_REL_B:    cmd.op = DP_REL_B;
         S_WALK:     if (!stat.cur_nil && !stat.expired) cmd.op = DP_WALK;
         S_DONE:     if (stat.rsp_free) cmd.op = DP_FINISH;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         suppress_ff <= 1'b0;
         status_ff   <= ST_OK;
      end else begin
         if (csr_bus.valid) suppress_ff <= csr_bus.data;
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               status_ff <= ST_OK;
               state_ff  <= S_DISPATCH;
            end
            S_DISPATCH: begin
               case (stat.operation)
                  OP_ALLOC: begin
                     if (suppress_ff) begin
                        status_ff <= ST_DUMMY;
                        state_ff  <= S_DONE;
                     end else if (stat.head_nil && !stat.oldest_nil) begin
                        state_ff <= S_REL_A;
                     end else if (!stat.head_nil) begin
                        state_ff <= S_POP_A;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
                  OP_FREE: state_ff <= S_FREE_CHK;
                  OP_REAP: state_ff <= S_WALK;
                  default: state_ff <= S_DONE;
               endcase
            end
            S_HEAD_RD: state_ff <= S_POP_A;
            S_POP_A:   state_ff <= S_POP_B;
            S_POP_B:   state_ff <= S_DONE;
            S_FREE_CHK: begin
               if (stat.cur_active) begin
                  state_ff <= S_REL_A;
               end else begin
                  status_ff <= ST_INACTIVE;
                  state_ff  <= S_DONE;
               end
            end
            S_REL_A: state_ff <= S_REL_B;
            S_REL_B: state_ff <= (stat.operation == OP_ALLOC) ? S_HEAD_RD : S_DONE;
            S_WALK: begin
               if (stat.cur_nil) begin
                  status_ff <= ST_NONE;
                  state_ff  <= S_DONE;
               end else if (stat.expired) begin
                  state_ff <= S_REL_A;
               end
            end
            S_DONE: if (stat.rsp_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: sv/pool_allocator_oldest_eviction.sv
// pool_allocator_oldest_eviction: top level joining sequencer and datapath
// depends on poe_pkg, poe_if, poe_ctrl and poe_datapath
//
// req_bus takes one word per operation: alloc, free of a slot, or reap of the
// oldest expired slot. rsp_bus returns exactly one word per request, in order.
// csr_bus writes the suppress bit at any cycle; ready is always high.
// One request is worked at a time; a new one is taken as soon as the last
// result sits in the response register, even if rsp_bus is still stalled.
// A reap walks the unexpired slots, oldest first, through the link
// memories until it finds an expired slot or reaches the end of the list.
// The sequence is set by the single read port of the link memories: each list
// step is a registered read followed by a write.
// Reset clears the list pointers and the fill count; slots at or above
// the fill count read as never allocated, so there is no clearing pass.
// While rsp_bus stalls, the finished word holds and the next one waits in
// the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module pool_allocator_oldest_eviction import poe_pkg::*; #(
   parameter int POOL_ENTRIES = 512
) (
   input wire logic clock,
   input wire logic reset,
   poe_req_if.sink   req_bus,
   poe_rsp_if.source rsp_bus,
   poe_csr_if.sink   csr_bus
);
   poe_cmd_type  cmd;
   poe_stat_type stat;

   poe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_bus   (csr_bus),
      .stat      (stat),
      .cmd       (cmd)
   );

   poe_datapath #(.POOL_ENTRIES(POOL_ENTRIES)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_bus.data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_bus.data)
   );
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// tb_top: self-checking testbench for pool_allocator_oldest_eviction
// drives alloc/free/reap/op 3 with random idling, predicts each response word
// depends on poe_pkg, poe_if and the pool_allocator_oldest_eviction rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import poe_pkg::*;

   localparam int NSLOT = 512;
   localparam int NIL = 512;
   localparam int LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   poe_req_if req_bus ();
   poe_rsp_if rsp_bus ();
   poe_csr_if csr_bus ();

   pool_allocator_oldest_eviction dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   // predicted pool state
   int unsigned pool_next[NSLOT];
   int unsigned pool_prev[NSLOT];
   logic [31:0] pool_end[NSLOT];
   bit          pool_live[NSLOT];
   int unsigned free_top, newest, oldest, live_total;
   bit          suppress;

   poe_rsp_type expected_words[$];
   int          errors = 0;
   int          cycles = 0;
   bit          sink_idle_on = 1'b1;
   bit          src_idle_on = 1'b1;
   int          hold_off = 0;

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void pool_reset();
      for (int i = 0; i < NSLOT; i++) begin
         pool_next[i] = i + 1;
         pool_live[i] = 1'b0;
      end
      free_top = 0; newest = NIL; oldest = NIL; live_total = 0; suppress = 1'b0;
   endfunction

   function automatic void pool_release(int unsigned s);
      int unsigned nw, od;
      nw = pool_prev[s];
      od = pool_next[s];
      if (nw < NIL) pool_next[nw] = od; else newest = od;
      if (od < NIL) pool_prev[od] = nw; else oldest = nw;
      pool_next[s] = free_top;
      free_top = s;
      pool_live[s] = 1'b0;
      if (live_total > 0) live_total--;
   endfunction

   function automatic poe_rsp_type pool_predict(poe_req_type w);
      poe_rsp_type r;
      int unsigned s, n;
      logic [32:0] sum;
      bit found;
      r = '0;
      if (w.operation == OP_ALLOC) begin
         if (suppress) begin
            r.status = ST_DUMMY;
         end else begin
            if (free_top >= NIL && oldest < NIL) begin
               r.evicted = 1'b1;
               r.evicted_slot = oldest[8:0];
               pool_release(oldest);
            end
            s = free_top;
            if (s < NIL) begin
               free_top = pool_next[s];
               pool_next[s] = newest;
               pool_prev[s] = NIL;
               if (newest < NIL) pool_prev[newest] = s; else oldest = s;
               newest = s;
               sum = {1'b0, w.now} + {9'd0, w.duration};
               pool_end[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               pool_live[s] = 1'b1;
               live_total++;
               r.result_slot = s[8:0];
            end
         end
      end else if (w.operation == OP_FREE) begin
         r.result_slot = w.slot;
         if (pool_live[w.slot]) pool_release(w.slot);
         else r.status = ST_INACTIVE;
      end else if (w.operation == OP_REAP) begin
         s = oldest; n = 0; found = 1'b0;
         while (s < NIL && n < NSLOT) begin
            if (w.now >= pool_end[s]) begin
               found = 1'b1;
               break;
            end
            s = pool_prev[s];
            n++;
         end
         if (found) begin
            r.result_slot = s[8:0];
            pool_release(s);
         end else begin
            r.status = ST_NONE;
         end
      end
      r.active_count = live_total[9:0];
      return r;
   endfunction

   task automatic send_word(logic [1:0] op, logic [31:0] now_ms, logic [23:0] dur,
                            logic [8:0] slot);
      poe_req_type w;
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      w.operation = op; w.now = now_ms; w.duration = dur; w.slot = slot;
      req_bus.valid <= 1'b1;
      req_bus.data <= w;
      do @(posedge clock); while (!req_bus.ready);
      expected_words.push_back(pool_predict(w));
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_suppress(bit v);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      suppress = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // response checker and sink stalls
   always @(posedge clock) begin
      poe_rsp_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.data;
         if (expected_words.size() == 0) begin
            $display("%0t unexpected word: actual %h", $time, got);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (got.status !== want.status)
               $display("%0t status: expected %0d actual %0d", $time, want.status,
                        got.status);
            if (got.result_slot !== want.result_slot)
               $display("%0t result_slot: expected %0d actual %0d", $time,
                        want.result_slot, got.result_slot);
            if (got.evicted !== want.evicted)
               $display("%0t evicted: expected %0d actual %0d", $time, want.evicted,
                        got.evicted);
            if (got.evicted_slot !== want.evicted_slot)
               $display("%0t evicted_slot: expected %0d actual %0d", $time,
                        want.evicted_slot, got.evicted_slot);
            if (got.active_count !== want.active_count)
               $display("%0t active_count: expected %0d actual %0d", $time,
                        want.active_count, got.active_count);
            if (got !== want) errors++;
         end
      end
   end

   initial begin
      int gap;
      gap = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off = hold_off - 1;
         end else if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
         end
      end
   end

   task automatic test_directed();
      send_word(OP_FREE, 0, 0, 9'd0);
      send_word(OP_REAP, 32'hFFFF_FFFF, 0, 0);
      send_word(OP_ALLOC, 32'hFFFF_FFFF, 24'hFF_FFFF, 9'h1FF);
      send_word(OP_ALLOC, 0, 0, 0);
      send_word(OP_ALLOC, 32'h8000_0000, 24'h80_0000, 0);
      send_word(OP_REAP, 0, 0, 0);
      send_word(OP_REAP, 32'h0000_0001, 0, 0);
      send_word(OP_FREE, 0, 0, 9'd0);
      send_word(OP_FREE, 0, 0, 9'd0);
      send_word(OP_FREE, 0, 0, 9'h1FF);
      send_word(2'd3, 32'hFFFF_FFFF, 24'hFF_FFFF, 9'h1FF);
      send_word(OP_REAP, 32'hFFFF_FFFF, 0, 0);
      send_word(OP_REAP, 32'hFFFF_FFFE, 0, 0);
      drain();
      write_suppress(1'b1);
      send_word(OP_ALLOC, 5, 5, 0);
      send_word(OP_FREE, 0, 0, 9'd1);
      send_word(OP_REAP, 32'hFFFF_FFFF, 0, 0);
      drain();
      write_suppress(1'b0);
   endtask

   // fill the pool past full so allocs evict, with a long stall on the rsp side
   task automatic test_fill_and_evict();
      hold_off = 200;
      for (int i = 0; i < 540; i++)
         send_word(OP_ALLOC, $urandom(), 24'($urandom_range(0, 1000)), 9'($urandom()));
      drain();
   endtask

   task automatic test_random();
      int unsigned clk_ms;
      int k;
      clk_ms = $urandom_range(0, 1000);
      for (int i = 0; i < 500; i++) begin
         if (i == 400) begin
            src_idle_on = 1'b0;
            sink_idle_on = 1'b0;
         end
         clk_ms += $urandom_range(0, 50);
         k = $urandom_range(0, 19);
         if (k < 8)
            send_word(OP_ALLOC, clk_ms, 24'($urandom_range(0, 300)), 9'($urandom()));
         else if (k < 13)
            send_word(OP_FREE, $urandom(), 24'($urandom()),
                      $urandom_range(0, 4) == 0 ? 9'($urandom()) : 9'(newest < NIL ?
                      ($urandom_range(0, 1) ? newest : oldest) : $urandom()));
         else if (k < 19)
            send_word(OP_REAP, $urandom_range(0, 3) == 0 ? $urandom() : clk_ms,
                      24'($urandom()), 9'($urandom()));
         else
            send_word(2'd3, $urandom(), 24'($urandom()), 9'($urandom()));
         if (i == 150 || i == 300) begin
            drain();
            write_suppress(i == 150);
         end
      end
      drain();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = 1'b0;
      pool_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_fill_and_evict();
      test_random();
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
